// ----- rtl/clrc_pkg.sv -----
// shared types and constants of the led color roi classifier
`default_nettype none
package clrc_pkg;

   localparam int unsigned MAX_REGION_MACROPIXELS_DEFAULT = 256;

   localparam int unsigned NUM_REGS = 8;
   localparam int unsigned REG_IDX_W = $clog2(NUM_REGS);
   localparam int unsigned CSR_ADDR_W = REG_IDX_W + 2;
   localparam int unsigned CSR_DATA_W = 32;

   // register indexes
   localparam logic [REG_IDX_W-1:0] REG_Q1_MIN_V = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_Q1_MIN_U = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_Q2_MIN_V = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_Q2_MAX_U = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_Q3_MAX_V = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_Q3_MAX_U = 3'd5;
   localparam logic [REG_IDX_W-1:0] REG_Q4_MAX_V = 3'd6;
   localparam logic [REG_IDX_W-1:0] REG_Q4_MIN_U = 3'd7;

   typedef logic [NUM_REGS-1:0][7:0] thresh_type;

   // reset values, index 7 down to index 0
   localparam thresh_type THRESH_RESET = {
      8'd145, 8'd100, 8'd130, 8'd110, 8'd100, 8'd140, 8'd140, 8'd140
   };

   // led state codes
   localparam logic [2:0] LED_OFF = 3'd0;
   localparam logic [2:0] LED_Q1  = 3'd1;
   localparam logic [2:0] LED_Q2  = 3'd2;
   localparam logic [2:0] LED_Q3  = 3'd3;
   localparam logic [2:0] LED_Q4  = 3'd4;

   localparam logic [7:0] NO_LUMA_AVERAGE = 8'd128;
   localparam logic [7:0] AVERAGE_MAX = 8'd255;

   // quotient bits of the rounded mean, one extra bit for the clamp
   localparam int unsigned QUOT_W = 9;
   localparam int unsigned STEP_W = $clog2(QUOT_W);

   typedef struct packed {
      logic [7:0] chroma_u;
      logic [7:0] luma_first;
      logic [7:0] chroma_v;
      logic [7:0] luma_second;
      logic       has_pixel;
      logic       region_end;
   } req_item_type;

   typedef struct packed {
      logic [7:0] average_u;
      logic [7:0] average_v;
      logic [2:0] led_state;
   } rsp_item_type;

   typedef struct packed {
      logic accumulate;
      logic div_load;
      logic div_step;
      logic finish;
   } ctrl_cmd_type;

endpackage
`default_nettype wire

// ----- rtl/clrc_csr.sv -----
// threshold registers behind the apb-style port
`default_nettype none
module clrc_csr (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           psel,
   input  wire logic                           penable,
   input  wire logic                           pwrite,
   input  wire logic [clrc_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [clrc_pkg::CSR_DATA_W-1:0] pwdata,
   output logic      [clrc_pkg::CSR_DATA_W-1:0] prdata,
   output logic                                pready,
   output clrc_pkg::thresh_type                thresh
);
   import clrc_pkg::*;

   thresh_type                 thresh_ff;
   thresh_type                 thresh_in;
   logic       [REG_IDX_W-1:0] reg_idx;

   assign reg_idx = paddr[CSR_ADDR_W-1:2];

   always_comb begin
      thresh_in = thresh_ff;
      if (psel && penable && pwrite) begin
         thresh_in[reg_idx] = pwdata[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= THRESH_RESET;
      end else begin
         thresh_ff <= thresh_in;
      end
   end

   assign prdata = {{(CSR_DATA_W-8){1'b0}}, thresh_ff[reg_idx]};
   assign pready = 1'b1;
   assign thresh = thresh_ff;

endmodule
`default_nettype wire

// ----- rtl/clrc_ctrl.sv -----
// sequencer: accumulate items, then run the mean division and classify
`default_nettype none
module clrc_ctrl (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           start,
   input  wire logic           region_end,
   output logic                busy,
   output logic                rsp_valid,
   output clrc_pkg::ctrl_cmd_type cmd
);
   import clrc_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOAD,
      ST_DIV,
      ST_FINISH
   } state_type;

   state_type          state_ff;
   state_type          state_in;
   logic               busy_ff;
   logic               busy_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic [STEP_W-1:0]  step_ff;
   logic [STEP_W-1:0]  step_in;
   logic               accept;

   assign accept = start && !busy_ff;

   always_comb begin
      state_in     = state_ff;
      busy_in      = busy_ff;
      rsp_valid_in = 1'b0;
      step_in      = step_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && region_end) begin
               state_in = ST_LOAD;
               busy_in  = 1'b1;
            end
         end
         ST_LOAD: begin
            state_in = ST_DIV;
            step_in  = '0;
         end
         ST_DIV: begin
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(QUOT_W - 1)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            state_in     = ST_IDLE;
            busy_in      = 1'b0;
            rsp_valid_in = 1'b1;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         step_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
         step_ff      <= step_in;
      end
   end

   assign cmd.accumulate = accept;
   assign cmd.div_load   = (state_ff == ST_LOAD);
   assign cmd.div_step   = (state_ff == ST_DIV);
   assign cmd.finish     = (state_ff == ST_FINISH);
   assign busy           = busy_ff;
   assign rsp_valid      = rsp_valid_ff;

endmodule
`default_nettype wire

// ----- rtl/clrc_datapath.sv -----
// accumulators, two restoring dividers and the quadrant classifier
`default_nettype none
module clrc_datapath #(
   parameter int unsigned MAX_REGION_MACROPIXELS = clrc_pkg::MAX_REGION_MACROPIXELS_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire clrc_pkg::req_item_type req_item,
   input  wire clrc_pkg::ctrl_cmd_type cmd,
   input  wire clrc_pkg::thresh_type   thresh,
   output clrc_pkg::rsp_item_type     rsp_item
);
   import clrc_pkg::*;

   localparam int unsigned WSUM_BOUND_INT = MAX_REGION_MACROPIXELS * 65025;
   localparam int unsigned LSUM_BOUND_INT = MAX_REGION_MACROPIXELS * 255;
   localparam int unsigned WSUM_W = $clog2(WSUM_BOUND_INT + 1);
   localparam int unsigned LSUM_W = $clog2(LSUM_BOUND_INT + 1);
   localparam int unsigned NUM_W = WSUM_W + 2;
   localparam int unsigned DSH_W = LSUM_W + QUOT_W;
   localparam int unsigned CMP_W = (NUM_W > DSH_W) ? NUM_W : DSH_W;
   localparam logic [WSUM_W-1:0] WSUM_BOUND = WSUM_W'(WSUM_BOUND_INT);
   localparam logic [LSUM_W-1:0] LSUM_BOUND = LSUM_W'(LSUM_BOUND_INT);

   // lane 0 is u over first luma, lane 1 is v over second luma
   logic [1:0][WSUM_W-1:0] wsum_ff;
   logic [1:0][WSUM_W-1:0] wsum_in;
   logic [1:0][LSUM_W-1:0] lsum_ff;
   logic [1:0][LSUM_W-1:0] lsum_in;
   logic [1:0][15:0]       prod;
   logic [1:0][7:0]        luma;
   logic [1:0][WSUM_W:0]   wsum_add;
   logic [1:0][LSUM_W:0]   lsum_add;
   logic [1:0][CMP_W-1:0]  rem_ff;
   logic [1:0][CMP_W-1:0]  rem_in;
   logic [1:0][CMP_W-1:0]  dsh_ff;
   logic [1:0][CMP_W-1:0]  dsh_in;
   logic [1:0][QUOT_W-1:0] quot_ff;
   logic [1:0][QUOT_W-1:0] quot_in;
   logic [1:0][7:0]        avg;
   logic [2:0]             led;
   rsp_item_type           rsp_ff;
   rsp_item_type           rsp_in;

   assign prod[0] = req_item.chroma_u * req_item.luma_first;
   assign prod[1] = req_item.chroma_v * req_item.luma_second;
   assign luma[0] = req_item.luma_first;
   assign luma[1] = req_item.luma_second;

   // saturating accumulation, cleared at finish
   always_comb begin
      for (int i = 0; i < 2; i++) begin
         wsum_add[i] = {1'b0, wsum_ff[i]} + (WSUM_W + 1)'(prod[i]);
         lsum_add[i] = {1'b0, lsum_ff[i]} + (LSUM_W + 1)'(luma[i]);
         wsum_in[i]  = wsum_ff[i];
         lsum_in[i]  = lsum_ff[i];
         if (cmd.finish) begin
            wsum_in[i] = '0;
            lsum_in[i] = '0;
         end else if (cmd.accumulate && req_item.has_pixel) begin
            wsum_in[i] = (wsum_add[i] > (WSUM_W + 1)'(WSUM_BOUND)) ?
                         WSUM_BOUND : wsum_add[i][WSUM_W-1:0];
            lsum_in[i] = (lsum_add[i] > (LSUM_W + 1)'(LSUM_BOUND)) ?
                         LSUM_BOUND : lsum_add[i][LSUM_W-1:0];
         end
      end
   end

   // (2w + l) / (2l), one quotient bit per step, msb first
   always_comb begin
      for (int i = 0; i < 2; i++) begin
         rem_in[i]  = rem_ff[i];
         dsh_in[i]  = dsh_ff[i];
         quot_in[i] = quot_ff[i];
         if (cmd.div_load) begin
            rem_in[i]  = CMP_W'({wsum_ff[i], 1'b0}) + CMP_W'(lsum_ff[i]);
            dsh_in[i]  = CMP_W'({lsum_ff[i], {QUOT_W{1'b0}}});
            quot_in[i] = '0;
         end else if (cmd.div_step) begin
            dsh_in[i] = dsh_ff[i] >> 1;
            if (rem_ff[i] >= dsh_ff[i]) begin
               rem_in[i]  = rem_ff[i] - dsh_ff[i];
               quot_in[i] = {quot_ff[i][QUOT_W-2:0], 1'b1};
            end else begin
               quot_in[i] = {quot_ff[i][QUOT_W-2:0], 1'b0};
            end
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 2; i++) begin
         if (lsum_ff[i] == '0) begin
            avg[i] = NO_LUMA_AVERAGE;
         end else if (quot_ff[i][QUOT_W-1]) begin
            avg[i] = AVERAGE_MAX;
         end else begin
            avg[i] = quot_ff[i][7:0];
         end
      end
   end

   // first matching quadrant wins
   always_comb begin
      priority if (avg[1] > thresh[REG_Q1_MIN_V] && avg[0] > thresh[REG_Q1_MIN_U]) begin
         led = LED_Q1;
      end else if (avg[1] > thresh[REG_Q2_MIN_V] && avg[0] < thresh[REG_Q2_MAX_U]) begin
         led = LED_Q2;
      end else if (avg[1] < thresh[REG_Q3_MAX_V] && avg[0] < thresh[REG_Q3_MAX_U]) begin
         led = LED_Q3;
      end else if (avg[1] < thresh[REG_Q4_MAX_V] && avg[0] > thresh[REG_Q4_MIN_U]) begin
         led = LED_Q4;
      end else begin
         led = LED_OFF;
      end
   end

   always_comb begin
      rsp_in = rsp_ff;
      if (cmd.finish) begin
         rsp_in.average_u = avg[0];
         rsp_in.average_v = avg[1];
         rsp_in.led_state = led;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wsum_ff <= '0;
         lsum_ff <= '0;
      end else begin
         wsum_ff <= wsum_in;
         lsum_ff <= lsum_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      dsh_ff  <= dsh_in;
      quot_ff <= quot_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_item = rsp_ff;

endmodule
`default_nettype wire

// ----- rtl/led_color_roi_classifier_top.sv -----
// top level of the led color roi classifier
//
// usage
//  - input channel: an item is taken at a clock edge with start high and busy low;
//    req_item carries one uyvy macro pixel (has_pixel) and the region_end flag
//  - an item without region_end leaves busy low, so macro pixels
//    stream in at one per cycle
//  - an item with region_end raises busy while two restoring
//    dividers form the rounded means (one quotient bit per cycle, 9 bits)
//  - the result shows on rsp_item with rsp_valid high for exactly one cycle,
//    once the division is done; busy is already low then
//  - the receiver cannot stall: every strobe is taken as it comes
//  - an empty region (no pixel) reports 128 for both means
//  - configuration: eight 8-bit thresholds on an apb-style port at 4*index, pready
//    tied high; the user must write them only while the block is idle (unenforced)
//  - reset (synchronous, active high) restores the thresholds, clears the
//    sums and drops busy and rsp_valid
`default_nettype none
module led_color_roi_classifier_top #(
   parameter int unsigned MAX_REGION_MACROPIXELS = clrc_pkg::MAX_REGION_MACROPIXELS_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // input channel
   input  wire logic                            start,
   output logic                                 busy,
   input  wire clrc_pkg::req_item_type          req_item,
   // result channel
   output logic                                 rsp_valid,
   output clrc_pkg::rsp_item_type               rsp_item,
   // configuration port
   input  wire logic                            psel,
   input  wire logic                            penable,
   input  wire logic                            pwrite,
   input  wire logic [clrc_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [clrc_pkg::CSR_DATA_W-1:0] pwdata,
   output logic      [clrc_pkg::CSR_DATA_W-1:0] prdata,
   output logic                                 pready
);
   import clrc_pkg::*;

   thresh_type   thresh;
   ctrl_cmd_type cmd;

   // threshold register file
   clrc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .thresh  (thresh)
   );

   // sequencer: accumulate, load dividers, 9 division steps, finish
   clrc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .region_end (req_item.region_end),
      .busy       (busy),
      .rsp_valid  (rsp_valid),
      .cmd        (cmd)
   );

   // sums, dividers and classifier
   clrc_datapath #(
      .MAX_REGION_MACROPIXELS (MAX_REGION_MACROPIXELS)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_item (req_item),
      .cmd      (cmd),
      .thresh   (thresh),
      .rsp_item (rsp_item)
   );

endmodule
`default_nettype wire

// ----- rtl/clrc_checker.sv -----
// port-level checks of the classifier, bound to the top level
`default_nettype none
module clrc_checker (
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   start,
   input wire logic                   busy,
   input wire clrc_pkg::req_item_type req_item,
   input wire logic                   rsp_valid
);
   import clrc_pkg::*;

   // region end takes the block busy
   assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_item.region_end |=> busy)
      else $error("region end item did not raise busy");

   // a result comes a fixed time after the region end item
   assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_item.region_end |-> ##12 rsp_valid)
      else $error("result missing after region end");

   // result strobe is a single cycle and comes with busy low
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy ##1 !rsp_valid)
      else $error("result strobe longer than a cycle or while busy");

   // reset leaves the block idle
   assert property (@(posedge clock)
      reset |=> !busy && !rsp_valid)
      else $error("block not idle after reset");

endmodule

bind led_color_roi_classifier_top clrc_checker u_clrc_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_item  (req_item),
   .rsp_valid (rsp_valid)
);
`default_nettype wire

// ----- sim/testbench.sv -----
// self-checking testbench of the led color roi classifier: directed table, then random regions
module testbench;
   import clrc_pkg::*;

   localparam int unsigned PIXEL_BOUND   = MAX_REGION_MACROPIXELS_DEFAULT;
   localparam int unsigned WEIGHT_LIMIT  = PIXEL_BOUND * 65025;
   localparam int unsigned LUMA_LIMIT    = PIXEL_BOUND * 255;
   localparam int unsigned STALL_LIMIT   = 500;
   localparam int          SETTLE_CYCLES = 16;
   localparam int          DRAIN_CYCLES  = 20;
   localparam int          PHASE_ITEMS   = 90;
   localparam int          NUM_PHASES    = 6;

   typedef struct {
      req_item_type item;
      bit           known;
      rsp_item_type want;
   } directed_row_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  start;
   logic                  busy;
   req_item_type          req_item;
   logic                  rsp_valid;
   rsp_item_type          rsp_item;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   // predictor state: thresholds and the four running sums
   logic [7:0]   thresholds [NUM_REGS];
   logic [23:0]  u_weight_sum;
   logic [15:0]  y0_sum;
   logic [23:0]  v_weight_sum;
   logic [15:0]  y1_sum;
   rsp_item_type pending_results [$];

   bit failed;
   int items_sent;
   int idle_pct;

   led_color_roi_classifier_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always #10 clock = ~clock;

   function automatic int unsigned capped_sum(int unsigned acc, int unsigned term,
                                              int unsigned limit);
      int unsigned total;
      total = acc + term;
      return (total > limit) ? limit : total;
   endfunction

   // round half up, clamp to a byte, 128 with no luma
   function automatic logic [7:0] rounded_average(logic [23:0] weighted, logic [15:0] luma);
      longint unsigned w2;
      longint unsigned l2;
      longint unsigned quotient;
      if (luma == 16'd0) return NO_LUMA_AVERAGE;
      w2 = weighted;
      l2 = luma;
      quotient = (2 * w2 + l2) / (2 * l2);
      return (quotient > 255) ? 8'd255 : 8'(quotient);
   endfunction

   // first matching quadrant wins
   function automatic logic [2:0] led_for(logic [7:0] au, logic [7:0] av);
      if (av > thresholds[REG_Q1_MIN_V] && au > thresholds[REG_Q1_MIN_U]) return LED_Q1;
      if (av > thresholds[REG_Q2_MIN_V] && au < thresholds[REG_Q2_MAX_U]) return LED_Q2;
      if (av < thresholds[REG_Q3_MAX_V] && au < thresholds[REG_Q3_MAX_U]) return LED_Q3;
      if (av < thresholds[REG_Q4_MAX_V] && au > thresholds[REG_Q4_MIN_U]) return LED_Q4;
      return LED_OFF;
   endfunction

   function automatic req_item_type make_item(int u, int y0, int v, int y1, int px, int last);
      req_item_type it;
      it.chroma_u    = 8'(u);
      it.luma_first  = 8'(y0);
      it.chroma_v    = 8'(v);
      it.luma_second = 8'(y1);
      it.has_pixel   = 1'(px);
      it.region_end  = 1'(last);
      return it;
   endfunction

   function automatic int clamp_byte(int value);
      if (value < 0) return 0;
      if (value > 255) return 255;
      return value;
   endfunction

   // accumulate one item; on region end form the verdict and clear the sums
   task automatic absorb_item(input req_item_type it, output bit closes,
                              output rsp_item_type verdict);
      verdict = '0;
      closes  = it.region_end;
      if (it.has_pixel) begin
         u_weight_sum = 24'(capped_sum(u_weight_sum,
                                       32'(it.chroma_u) * 32'(it.luma_first), WEIGHT_LIMIT));
         y0_sum       = 16'(capped_sum(y0_sum, 32'(it.luma_first), LUMA_LIMIT));
         v_weight_sum = 24'(capped_sum(v_weight_sum,
                                       32'(it.chroma_v) * 32'(it.luma_second), WEIGHT_LIMIT));
         y1_sum       = 16'(capped_sum(y1_sum, 32'(it.luma_second), LUMA_LIMIT));
      end
      if (it.region_end) begin
         verdict.average_u = rounded_average(u_weight_sum, y0_sum);
         verdict.average_v = rounded_average(v_weight_sum, y1_sum);
         verdict.led_state = led_for(verdict.average_u, verdict.average_v);
         u_weight_sum = '0;
         y0_sum       = '0;
         v_weight_sum = '0;
         y1_sum       = '0;
      end
   endtask

   task automatic hold_off();
      @(negedge clock);
      start <= 1'b0;
   endtask

   task automatic drain_results();
      hold_off();
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic send_item(input req_item_type it, input bit known, input rsp_item_type want);
      bit           closes;
      rsp_item_type verdict;
      if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
         repeat ($urandom_range(1, 4)) hold_off();
      else if (idle_pct > 0 && $urandom_range(0, 199) == 0)
         drain_results();
      @(negedge clock);
      start    <= 1'b1;
      req_item <= it;
      do @(posedge clock); while (busy);
      absorb_item(it, closes, verdict);
      if (closes) pending_results.push_back(known ? want : verdict);
      items_sent++;
   endtask

   // one region: chroma jittered around a base, inverted from flip_at on,
   // with stray empty markers mixed in
   task automatic send_region(input int pixel_count, input int flip_at, input int base_u,
                              input int base_v, input int spread, input int luma_lo,
                              input int luma_hi, input bit marker_end);
      req_item_type it;
      int           u;
      int           v;
      for (int n = 0; n < pixel_count; n++) begin
         if ($urandom_range(0, 9) == 0) begin
            it = req_item_type'({$urandom, 2'b00});
            send_item(it, 1'b0, '0);
         end
         u = (n >= flip_at) ? 255 - base_u : base_u;
         v = (n >= flip_at) ? 255 - base_v : base_v;
         u = clamp_byte(u + int'($urandom_range(0, 2 * spread)) - spread);
         v = clamp_byte(v + int'($urandom_range(0, 2 * spread)) - spread);
         it = make_item(u, int'($urandom_range(luma_lo, luma_hi)), v,
                        int'($urandom_range(luma_lo, luma_hi)), 1,
                        (!marker_end && n == pixel_count - 1) ? 1 : 0);
         send_item(it, 1'b0, '0);
      end
      if (marker_end || pixel_count == 0) begin
         it = req_item_type'({$urandom, 2'b01});
         send_item(it, 1'b0, '0);
      end
   endtask

   task automatic csr_write(input logic [REG_IDX_W-1:0] index, input logic [7:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {index, 2'b00};
      pwdata  <= {24'd0, value};
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      thresholds[index] = value;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic csr_read(input logic [REG_IDX_W-1:0] index);
      logic [CSR_DATA_W-1:0] want;
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= {index, 2'b00};
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      want = {24'd0, thresholds[index]};
      if (prdata !== want) begin
         $display("%0t: register %0d read %h, expected %h", $time, index, prdata, want);
         failed = 1'b1;
      end
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // only while idle: every result in, then margin for the divider
   task automatic program_thresholds(input logic [7:0] setting [NUM_REGS]);
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      for (int i = 0; i < NUM_REGS; i++) csr_write(REG_IDX_W'(i), setting[i]);
      for (int i = 0; i < NUM_REGS; i++) csr_read(REG_IDX_W'(i));
   endtask

   // result checker
   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result %h", $time, rsp_item);
            failed = 1'b1;
         end else begin
            want = pending_results.pop_front();
            if (rsp_item.average_u !== want.average_u) begin
               $display("%0t: average_u expected %0d, got %0d",
                        $time, want.average_u, rsp_item.average_u);
               failed = 1'b1;
            end
            if (rsp_item.average_v !== want.average_v) begin
               $display("%0t: average_v expected %0d, got %0d",
                        $time, want.average_v, rsp_item.average_v);
               failed = 1'b1;
            end
            if (rsp_item.led_state !== want.led_state) begin
               $display("%0t: led_state expected %0d, got %0d",
                        $time, want.led_state, rsp_item.led_state);
               failed = 1'b1;
            end
         end
      end
   end

   // watchdog on cycles without any handshake
   initial begin : watchdog
      int unsigned quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((start && !busy) || rsp_valid || (psel && penable)) quiet_cycles = 0;
         else quiet_cycles++;
      end
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      directed_row_type rows [$];
      logic [7:0]       setting [NUM_REGS];
      int               phase_goal;
      int               pick;

      reset    = 1'b1;
      start    = 1'b0;
      req_item = '0;
      psel     = 1'b0;
      penable  = 1'b0;
      pwrite   = 1'b0;
      paddr    = '0;
      pwdata   = '0;
      failed     = 1'b0;
      items_sent = 0;
      idle_pct   = 20;
      thresholds[REG_Q1_MIN_V] = 8'd140;
      thresholds[REG_Q1_MIN_U] = 8'd140;
      thresholds[REG_Q2_MIN_V] = 8'd140;
      thresholds[REG_Q2_MAX_U] = 8'd100;
      thresholds[REG_Q3_MAX_V] = 8'd110;
      thresholds[REG_Q3_MAX_U] = 8'd130;
      thresholds[REG_Q4_MAX_V] = 8'd100;
      thresholds[REG_Q4_MIN_U] = 8'd145;
      u_weight_sum = '0;
      y0_sum       = '0;
      v_weight_sum = '0;
      y1_sum       = '0;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset values of the thresholds
      for (int i = 0; i < NUM_REGS; i++) csr_read(REG_IDX_W'(i));

      // empty region, extremes, zero luma, every quadrant
      rows.push_back('{make_item(0, 0, 0, 0, 0, 1), 1'b1, '{8'd128, 8'd128, LED_OFF}});
      rows.push_back('{make_item(255, 255, 255, 255, 1, 1), 1'b1, '{8'd255, 8'd255, LED_Q1}});
      rows.push_back('{make_item(0, 255, 0, 255, 1, 1), 1'b1, '{8'd0, 8'd0, LED_Q3}});
      rows.push_back('{make_item(255, 0, 255, 0, 1, 1), 1'b1, '{8'd128, 8'd128, LED_OFF}});
      rows.push_back('{make_item(0, 255, 255, 255, 1, 1), 1'b1, '{8'd0, 8'd255, LED_Q2}});
      rows.push_back('{make_item(255, 255, 0, 255, 1, 1), 1'b1, '{8'd255, 8'd0, LED_Q4}});
      rows.push_back('{make_item(200, 0, 50, 9, 1, 1), 1'b1, '{8'd128, 8'd50, LED_Q3}});
      // halves round up
      rows.push_back('{make_item(1, 1, 2, 1, 1, 0), 1'b0, '0});
      rows.push_back('{make_item(2, 1, 3, 1, 1, 1), 1'b0, '0});
      // empty markers inside a region and as its end
      rows.push_back('{make_item(10, 200, 10, 200, 1, 0), 1'b0, '0});
      rows.push_back('{make_item(255, 255, 255, 255, 0, 0), 1'b0, '0});
      rows.push_back('{make_item(255, 255, 255, 255, 0, 1), 1'b0, '0});
      // strict comparisons right at the default thresholds
      rows.push_back('{make_item(140, 1, 141, 1, 1, 1), 1'b0, '0});
      rows.push_back('{make_item(141, 1, 141, 1, 1, 1), 1'b0, '0});
      rows.push_back('{make_item(99, 1, 141, 1, 1, 1), 1'b0, '0});
      rows.push_back('{make_item(100, 1, 141, 1, 1, 1), 1'b0, '0});
      rows.push_back('{make_item(129, 1, 109, 1, 1, 1), 1'b0, '0});
      rows.push_back('{make_item(130, 1, 109, 1, 1, 1), 1'b0, '0});
      rows.push_back('{make_item(146, 1, 99, 1, 1, 1), 1'b0, '0});
      rows.push_back('{make_item(145, 1, 99, 1, 1, 1), 1'b0, '0});
      foreach (rows[i]) send_item(rows[i].item, rows[i].known, rows[i].want);

      // sender waits for every outstanding result at least once
      drain_results();

      for (int phase = 1; phase <= NUM_PHASES; phase++) begin
         for (int i = 0; i < NUM_REGS; i++) begin
            case (phase)
               2:       setting[i] = 8'd0;
               3:       setting[i] = 8'd255;
               5:       setting[i] = 8'($urandom_range(100, 160));
               default: setting[i] = 8'($urandom);
            endcase
         end
         program_thresholds(setting);
         idle_pct = (phase == 3 || phase == NUM_PHASES) ? 0 : int'($urandom_range(10, 35));

         // past the bound the sums stick, so the dark tail cannot pull the means down
         if (phase == 2) send_region(300, 270, 255, 255, 0, 255, 255, 1'b0);

         phase_goal = items_sent + PHASE_ITEMS;
         while (items_sent < phase_goal) begin
            pick = int'($urandom_range(0, 99));
            if (pick < 6)
               send_region(0, 0, 0, 0, 0, 0, 0, 1'b1);
            else if (pick < 14)
               send_region(int'($urandom_range(1, 5)), 99, int'($urandom_range(0, 255)),
                           int'($urandom_range(0, 255)), 12, 0, 0, 1'($urandom_range(0, 1)));
            else if (pick < 20)
               send_region(int'($urandom_range(16, 40)), int'($urandom_range(4, 40)),
                           int'($urandom_range(0, 255)), int'($urandom_range(0, 255)),
                           int'($urandom_range(0, 40)), 0, 255, $urandom_range(0, 3) == 0);
            else
               send_region(int'($urandom_range(1, 6)), 99, int'($urandom_range(0, 255)),
                           int'($urandom_range(0, 255)), int'($urandom_range(0, 20)),
                           0, (pick < 30) ? 3 : 255, $urandom_range(0, 6) == 0);
         end
      end

      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (!failed)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/clrc_pkg.sv
rtl/clrc_csr.sv
rtl/clrc_ctrl.sv
rtl/clrc_datapath.sv
rtl/led_color_roi_classifier_top.sv
rtl/clrc_checker.sv
sim/testbench.sv
